// ===== sv/sv39ptw_pkg.sv =====
// Shared types and constants for the Sv39 page table walker.
package sv39ptw_pkg;

   localparam int VaW      = 39;
   localparam int PteW     = 64;
   localparam int PpnW     = 44;
   localparam int AddrW    = 56;
   localparam int VpnW     = 9;
   localparam int OffW     = 12;
   localparam int ModeW    = 4;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = PpnW;
   localparam int ReqDataW = 104;
   localparam int RspDataW = 64;

   localparam logic [ModeW-1:0] ModeSv39 = 4'd8;

   localparam logic KindTranslate = 1'b0;
   localparam logic KindResponse  = 1'b1;
   localparam logic ResultRead    = 1'b0;
   localparam logic ResultDone    = 1'b1;

   localparam logic [CsrIdxW-1:0] CsrRootPage = 1'd0;
   localparam logic [CsrIdxW-1:0] CsrMode     = 1'd1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_BAD_MODE = 2'd2
   } status_type;

   typedef struct packed {
      logic                   kind;
      logic [AddrW-1:0]       address;
      status_type             status;
   } rsp_type;

endpackage

// ===== sv/sv39_page_table_walker_core.sv =====
// Sv39 page table walker: request/response sequencing with a registered result and skid stage.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | tuser = kind, tdata = virtual_address, read_data
//  rsp     | out       | rsp_tvalid/tready  | tuser = result_kind, tdata = address, status
//  csr     | in        | csr_we             | csr_addr = register index, csr_wdata = value
//
// Results are registered (output or skid register); one item per cycle while req_tready is high.
// The walk state is updated in the same cycle an item is accepted, so items may follow
// back to back. A skid register absorbs one result when rsp stalls; req_tready is low only
// while the skid register is full. Reset is synchronous; it clears control state and sets mode to Sv39.
module sv39_page_table_walker_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,   // kind
   input  logic [sv39ptw_pkg::ReqDataW-1:0]   req_tdata,   // virtual_address[38:0], read_data[102:39]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_tuser,   // result_kind
   output logic [sv39ptw_pkg::RspDataW-1:0]   rsp_tdata,   // address[55:0], status[57:56]
   input  logic                               csr_we,
   input  logic [sv39ptw_pkg::CsrIdxW-1:0]    csr_addr,
   input  logic [sv39ptw_pkg::CsrDataW-1:0]   csr_wdata
);
   import sv39ptw_pkg::*;

   logic [PpnW-1:0]  root_ppn_ff;
   logic [ModeW-1:0] mode_ff;
   logic             busy_ff, busy_in;
   logic [1:0]       level_ff, level_in;
   logic [VaW-1:0]   held_va_ff, held_va_in;

   rsp_type          out_ff, skid_ff, new_rsp;
   logic             out_valid_ff, skid_valid_ff;
   logic             push, pop, has_result;

   logic [VaW-1:0]   req_va;
   logic [PteW-1:0]  req_pte;
   logic [PpnW-1:0]  pte_ppn;
   logic [1:0]       next_level;
   logic [VpnW-1:0]  vpn_sel;

   assign req_va  = req_tdata[VaW-1:0];
   assign req_pte = req_tdata[VaW+PteW-1:VaW];
   assign pte_ppn = req_pte[10+PpnW-1:10];

   assign req_tready = !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ppn_ff <= '0;
         mode_ff     <= ModeSv39;
      end else if (csr_we) begin
         unique case (csr_addr)
            CsrRootPage: root_ppn_ff <= csr_wdata;
            CsrMode:     mode_ff     <= csr_wdata[ModeW-1:0];
            default:     ;
         endcase
      end
   end

   // Page number for the level being read next: VPN2, VPN1, VPN0.
   assign next_level = level_ff + 2'd1;
   always_comb begin
      unique case (next_level)
         2'd1:    vpn_sel = held_va_ff[29:21];
         2'd2:    vpn_sel = held_va_ff[20:12];
         default: vpn_sel = held_va_ff[38:30];
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      level_in   = level_ff;
      held_va_in = held_va_ff;
      has_result = 1'b0;
      new_rsp    = '{kind: ResultRead, address: '0, status: ST_OK};
      if (req_tvalid && req_tready) begin
         if (req_tuser == KindTranslate) begin
            if (!busy_ff) begin
               has_result = 1'b1;
               if (mode_ff != ModeSv39) begin
                  new_rsp = '{kind: ResultDone, address: '0, status: ST_BAD_MODE};
               end else begin
                  held_va_in = req_va;
                  level_in   = 2'd0;
                  busy_in    = 1'b1;
                  new_rsp    = '{kind: ResultRead,
                                 address: {root_ppn_ff, req_va[38:30], 3'b000},
                                 status: ST_OK};
               end
            end
         end else if (busy_ff) begin
            has_result = 1'b1;
            if (!req_pte[0]) begin
               busy_in  = 1'b0;
               level_in = 2'd0;
               new_rsp  = '{kind: ResultDone, address: '0, status: ST_INVALID};
            end else if (level_ff < 2'd2) begin
               level_in = next_level;
               new_rsp  = '{kind: ResultRead, address: {pte_ppn, vpn_sel, 3'b000},
                            status: ST_OK};
            end else begin
               busy_in  = 1'b0;
               level_in = 2'd0;
               new_rsp  = '{kind: ResultDone, address: {pte_ppn, held_va_ff[OffW-1:0]},
                            status: ST_OK};
            end
         end
      end
   end

   assign push = has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         level_ff      <= 2'd0;
         held_va_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         level_ff   <= level_in;
         held_va_ff <= held_va_in;
         if (skid_valid_ff) begin
            if (pop) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (!out_valid_ff || pop) begin
               out_ff       <= new_rsp;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= new_rsp;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {{(RspDataW-AddrW-2){1'b0}}, out_ff.status, out_ff.address};

   // A full skid register always sits behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_idle_level_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> level_ff == 2'd0)
      else $error("walk level nonzero while idle");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff != 2'd3)
      else $error("walk level out of range");

   a_fault_is_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != ST_OK |-> out_ff.kind == ResultDone && out_ff.address == '0)
      else $error("fault result is not a zero-address finished result");

   a_read_while_busy: assert property (@(posedge clock) disable iff (reset)
      push && new_rsp.kind == ResultRead |=> busy_ff)
      else $error("table read issued without an active walk");

endmodule
